>>> rtl/core/ecc_pkg.sv
// ----------------------------------------------------------------------------
// ecc_pkg
// Shared types and constants for the EBML cluster cut filter: the cluster ID
// byte sequence and the job word passed from the front end to the back end.
// ----------------------------------------------------------------------------
package ecc_pkg;

	localparam int CUT_W   = 16;
	localparam int TOTAL_W = 16;

	// cluster ID, entry 0 is the first byte on the wire
	localparam logic [3:0][7:0] ID_SEQ = {8'h75, 8'hB6, 8'h43, 8'h1F};

	// one input's worth of output beats
	typedef struct packed {
		logic [3:0][7:0]     bytes;     // beat k carries bytes[k]
		logic [1:0]          last_idx;  // index of the final beat
		logic                start;     // first beat opens the kept cluster
		logic                empty;     // single empty end marker
		logic                eos;       // input closed the stream
		logic [TOTAL_W-1:0]  total;     // cluster count after this input
	} job_t;

endpackage

>>> rtl/core/ecc_front.sv
// ----------------------------------------------------------------------------
// ecc_front
// Front end: matches the cluster ID, tracks filter mode and the saturating
// cluster count, and turns each accepted byte that yields output or ends the stream into a job for the back end.
// ----------------------------------------------------------------------------
module ecc_front import ecc_pkg::*; #(
	parameter int COUNT_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wen,
	input  logic [CUT_W-1:0] cfg_wdata,
	input  logic [7:0]       in_byte,
	input  logic             in_eos,
	input  logic             in_accept,
	output logic             job_valid,
	output job_t             job
);

	typedef enum logic [1:0] {
		MODE_HEADER = 2'd0,
		MODE_DROP   = 2'd1,
		MODE_PASS   = 2'd2
	} mode_t;

	localparam int CMP_W = (COUNT_BITS > CUT_W) ? COUNT_BITS : CUT_W;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	mode_t                 mode_q, mode_d;
	logic [1:0]            match_q, next_len;
	logic [COUNT_BITS-1:0] cnt_q, cnt_d;
	logic [CUT_W-1:0]      cut_q;
	logic                  found, extend, keep;
	logic [CMP_W-1:0]      cnt_ext, cut_ext;
	logic [2:0]            n_beats;
	logic [3:0][7:0]       bytes;
	logic                  start, empty;

	always_comb begin
		found    = 1'b0;
		next_len = 2'd0;
		if (in_byte == ID_SEQ[0]) begin
			next_len = 2'd1;
		end else if (match_q != 2'd0 && in_byte == ID_SEQ[match_q]) begin
			if (match_q == 2'd3) begin
				found = 1'b1;
			end else begin
				next_len = match_q + 2'd1;
			end
		end
		extend = !found && ({1'b0, next_len} == ({1'b0, match_q} + 3'd1));

		cnt_d   = (found && cnt_q != CNT_MAX) ? cnt_q + 1'b1 : cnt_q;
		cnt_ext = CMP_W'(cnt_d);
		cut_ext = CMP_W'(cut_q);
		keep    = cnt_ext > cut_ext;

		bytes   = ID_SEQ;
		n_beats = 3'd0;
		start   = 1'b0;
		mode_d  = mode_q;
		case (mode_q)
			MODE_HEADER, MODE_DROP: begin
				if (found) begin
					if (keep) begin
						n_beats = 3'd4;
						start   = 1'b1;
						mode_d  = MODE_PASS;
					end else begin
						mode_d  = MODE_DROP;
					end
				end else if (mode_q == MODE_HEADER) begin
					// held prefix bytes equal the ID; the current byte follows them
					bytes[match_q] = in_byte;
					if (extend) begin
						n_beats = in_eos ? {1'b0, match_q} + 3'd1 : 3'd0;
					end else if (next_len == 2'd1) begin
						n_beats = {1'b0, match_q} + {2'b00, in_eos};
					end else begin
						n_beats = {1'b0, match_q} + 3'd1;
					end
				end
			end
			default: begin
				n_beats  = 3'd1;
				bytes[0] = in_byte;
			end
		endcase

		empty         = (n_beats == 3'd0) && in_eos;
		job_valid     = (n_beats != 3'd0) || in_eos;
		job.bytes     = empty ? '0 : bytes;
		job.last_idx  = empty ? 2'd0 : 2'(n_beats - 3'd1);
		job.start     = start;
		job.empty     = empty;
		job.eos       = in_eos;
		job.total     = cnt_ext[TOTAL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_HEADER;
			match_q <= 2'd0;
			cnt_q   <= '0;
			cut_q   <= '0;
		end else begin
			if (cfg_wen) begin
				cut_q <= cfg_wdata;
			end
			if (in_accept) begin
				if (in_eos) begin
					mode_q  <= MODE_HEADER;
					match_q <= 2'd0;
					cnt_q   <= '0;
				end else begin
					mode_q  <= mode_d;
					match_q <= next_len;
					cnt_q   <= cnt_d;
				end
			end
		end
	end

endmodule

>>> rtl/core/ecc_fifo.sv
// ----------------------------------------------------------------------------
// ecc_fifo
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
module ecc_fifo import ecc_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t din,
	input  logic pop,
	output job_t dout,
	output logic full,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign dout  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/core/ecc_back.sv
// ----------------------------------------------------------------------------
// ecc_back
// Back end: unrolls the job at the queue head into output beats, one a
// cycle while out_ready is high, through a registered output stage.
// ----------------------------------------------------------------------------
module ecc_back import ecc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  job_t               head,
	input  logic               head_valid,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_byte,
	output logic               out_byte_valid,
	output logic               out_start,
	output logic [TOTAL_W-1:0] out_total,
	output logic               out_run_last,
	output logic               out_done
);

	logic       valid_q;
	logic [1:0] idx_q;
	logic       load, last;

	assign load      = head_valid && (!valid_q || out_ready);
	assign last      = (idx_q == head.last_idx);
	assign pop       = load && last;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= last ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// payload holds while the beat is stalled
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte       <= head.bytes[idx_q];
			out_byte_valid <= !head.empty;
			out_start      <= head.start && (idx_q == 2'd0);
			out_total      <= head.total;
			out_run_last   <= last;
			out_done       <= last && head.eos;
		end
	end

endmodule

>>> rtl/core/ebml_cluster_cut_filter.sv
// ----------------------------------------------------------------------------
// ebml_cluster_cut_filter
// Scans a byte stream for the EBML cluster ID, drops the first cut_count
// clusters and passes the rest, holding partial ID bytes until resolved.
// ----------------------------------------------------------------------------
// Path: each job goes through the job queue, then the registered output stage.
// Throughput: one input a cycle while each yields one beat and out_tready is
// high; an input that yields several beats holds the output stage for each,
// and the QUEUE_DEPTH-entry job queue absorbs bursts of up to four ID bytes.
// Reset: asynchronous; clears mode, match, count, cut_count and the queue.
// ----------------------------------------------------------------------------
module ebml_cluster_cut_filter import ecc_pkg::*; #(
	parameter int COUNT_BITS  = 16,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wen,
	input  logic [CUT_W-1:0] cfg_wdata,   // cut_count
	input  logic             in_tvalid,
	output logic             in_tready,
	input  logic [7:0]       in_tdata,    // [7:0] in_byte
	input  logic             in_tlast,    // end_of_stream
	output logic             out_tvalid,
	input  logic             out_tready,
	output logic [23:0]      out_tdata,   // [7:0] out_byte, [23:8] cluster_total
	output logic [2:0]       out_tuser,   // [0] byte_valid, [1] cluster_start,
	                                      // [2] stream_done
	output logic             out_tlast    // run_last
);

	logic               in_accept, job_valid, fifo_push, fifo_pop;
	logic               fifo_full, fifo_empty;
	job_t               job, head;
	logic [7:0]         o_byte;
	logic               o_bvalid, o_start, o_done;
	logic [TOTAL_W-1:0] o_total;

	assign in_tready = !fifo_full;
	assign in_accept = in_tvalid && in_tready;
	assign fifo_push = in_accept && job_valid;

	ecc_front #(
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_byte   (in_tdata),
		.in_eos    (in_tlast),
		.in_accept (in_accept),
		.job_valid (job_valid),
		.job       (job)
	);

	ecc_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fifo_push),
		.din    (job),
		.pop    (fifo_pop),
		.dout   (head),
		.full   (fifo_full),
		.empty  (fifo_empty)
	);

	ecc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.head_valid     (!fifo_empty),
		.pop            (fifo_pop),
		.out_valid      (out_tvalid),
		.out_ready      (out_tready),
		.out_byte       (o_byte),
		.out_byte_valid (o_bvalid),
		.out_start      (o_start),
		.out_total      (o_total),
		.out_run_last   (out_tlast),
		.out_done       (o_done)
	);

	assign out_tdata = {o_total, o_byte};
	assign out_tuser = {o_done, o_start, o_bvalid};

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_pop |-> !fifo_empty)
		else $error("job queue popped while empty");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_tvalid && out_tuser[2] |-> out_tlast)
		else $error("stream_done without run_last");

	a_empty_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_tvalid && !out_tuser[0] |-> out_tuser[2] && out_tdata[7:0] == 8'h00)
		else $error("empty beat is not a clean end marker");

	a_start_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_tvalid && out_tuser[1] |-> out_tdata[7:0] == ID_SEQ[0] && out_tuser[0])
		else $error("cluster_start on a byte other than the first ID byte");

endmodule
